// File: hw/rtl/link_join_ack_frame_responder_defines.svh
// ----------------------------------------------------------------------------
// Link join/ack frame responder: assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef LINK_JOIN_ACK_FRAME_RESPONDER_DEFINES_SVH
`define LINK_JOIN_ACK_FRAME_RESPONDER_DEFINES_SVH

// Same-cycle implication, held off during reset
`define LJAFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset
`define LJAFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ljafr_pkg.sv
// ----------------------------------------------------------------------------
// Link join/ack frame responder: package
// Request codes, frame constants, join subframe table and the control
// structures passed between controller and datapath.
// ----------------------------------------------------------------------------
package ljafr_pkg;

    // Request function codes
    typedef enum logic [1:0] {
        FN_CHILD   = 2'd0,
        FN_PEER    = 2'd1,
        FN_RESTART = 2'd2,
        FN_PULL    = 2'd3
    } t_func;

    // Reply sizing
    localparam int IDX_W            = 5;   // reply word index, up to 20 words
    localparam int BUF_WORDS        = 8;   // words of frame that can be non-zero
    localparam int BUF_BYTES        = 4 * BUF_WORDS;
    localparam int ACK_FRAME_BYTES  = 3;
    localparam int ROW_BYTES        = 14;
    localparam int TABLE_BYTES      = 70;
    localparam int ECHO_FRAME_BYTES = 3 + TABLE_BYTES;
    localparam int ECHO_LAST_IDX    = (ECHO_FRAME_BYTES + 3) / 4;
    localparam int KEPT_WORDS       = 4;

    // Link header codes
    localparam logic [3:0] ST_START   = 4'd1;
    localparam logic [3:0] ST_DATA    = 4'd2;
    localparam logic [3:0] ST_END     = 4'd3;
    localparam logic [3:0] ST_NULL    = 4'd0;
    localparam logic [3:0] ST_ECHO    = 4'd4;
    localparam logic [2:0] JOIN_LAST  = 3'd4;
    localparam logic [2:0] JOIN_DONE  = 3'd5;
    localparam logic [1:0] NULL_REPS  = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic             child_wr;
        logic             peer_wr;
        logic             restart;
        logic             pull_load;
        logic [IDX_W-1:0] word_idx;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [IDX_W-1:0] last_idx;
    } t_dp_sts;

    // Child header scanner state, with the latched acknowledgement
    typedef struct packed {
        logic [4:0] skip;
        logic       done;
        logic       half;
        logic [7:0] low;
        logic       ack_pending;
        logic [3:0] ack_kind;
        logic [1:0] ack_seq;
        logic [1:0] ack_phase;
    } t_scan;

    // One join subframe: header fields and up to five payload bytes
    typedef struct packed {
        logic [3:0]  st;
        logic [1:0]  sq;
        logic [1:0]  ph;
        logic [6:0]  size;
        logic [39:0] pay;
    } t_join_sub;

    function automatic t_join_sub join_entry(input logic [2:0] stage);
        t_join_sub e;
        e = '0;
        case (stage)
            3'd0: begin
                e.st = ST_START; e.sq = 2'd1; e.size = 7'd5; e.pay = 40'h00_01_00_05_00;
            end
            3'd1: begin
                e.st = ST_START; e.sq = 2'd2; e.size = 7'd2;
            end
            3'd2: begin
                e.st = ST_DATA; e.sq = 2'd1; e.size = 7'd1; e.pay = 40'h00_00_00_00_05;
            end
            3'd3: begin
                e.st = ST_END;
            end
            default: begin
                e.st = ST_NULL; e.sq = 2'd1;
            end
        endcase
        return e;
    endfunction

    // Three-byte link frame header
    function automatic logic [23:0] llsf_hdr(input logic [3:0] st, input logic ack,
                                             input logic [1:0] sq, input logic [1:0] ph,
                                             input logic [6:0] size);
        return {5'b0, 1'b1, st, ack, sq, ph, 2'b0, size};
    endfunction

endpackage

// File: hw/rtl/ljafr_ifs.sv
// ----------------------------------------------------------------------------
// Link join/ack frame responder: channel interfaces
// Request channel (slot words, restart, pull) and reply word channel.
// ----------------------------------------------------------------------------
interface ljafr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] word;
    logic        last;

    modport source (output valid, func, word, last, input ready);
    modport sink   (input valid, func, word, last, output ready);
    modport mon    (input valid, ready, func, word, last);
endinterface

interface ljafr_rep_if;
    logic        valid;
    logic        ready;
    logic [31:0] reply_word;
    logic        reply_last;

    modport source (output valid, reply_word, reply_last, input ready);
    modport sink   (input valid, reply_word, reply_last, output ready);
    modport mon    (input valid, ready, reply_word, reply_last);
endinterface

// File: hw/rtl/ljafr_datapath.sv
// ----------------------------------------------------------------------------
// Link join/ack frame responder: datapath
// Slot storage, child header scanner, join/ack state and the reply buffer
// that is built when a pull is taken.
// ----------------------------------------------------------------------------
module ljafr_datapath import ljafr_pkg::*; #(
    parameter int SLOT_WORDS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic [31:0] i_word,
    input  logic        i_last,
    output t_dp_sts     o_sts,
    output logic [31:0] o_reply_word
);

    localparam int CW = $clog2(SLOT_WORDS + 1);

    logic [2:0]       r_join_stage, n_join_stage;
    logic [1:0]       r_null_cnt, n_null_cnt;
    t_scan            r_scan, n_scan;
    logic [31:0]      r_child_words [KEPT_WORDS];
    logic [31:0]      n_child_words [KEPT_WORDS];
    logic [CW-1:0]    r_child_cnt, n_child_cnt;
    logic             r_child_open, n_child_open;
    logic [31:0]      r_peer_words [KEPT_WORDS];
    logic [31:0]      n_peer_words [KEPT_WORDS];
    logic [CW-1:0]    r_peer_cnt, n_peer_cnt;
    logic             r_peer_open, n_peer_open;
    logic [31:0]      r_buf [BUF_WORDS];
    logic [31:0]      n_buf [BUF_WORDS];
    logic [6:0]       r_hdr, n_hdr;
    logic [IDX_W-1:0] r_last_idx, n_last_idx;

    // Four header-scan steps over the bytes of one word, low byte first
    function automatic t_scan scan_word(input t_scan s_in, input logic [31:0] w);
        t_scan       s;
        logic [7:0]  by;
        logic [15:0] h;
        s = s_in;
        for (int j = 0; j < 4; j++) begin
            by = w[8*j +: 8];
            h  = {by, s.low};
            if (!s.done) begin
                if (s.skip != 5'd0) begin
                    s.skip = s.skip - 5'd1;
                end else if (!s.half) begin
                    s.low  = by;
                    s.half = 1'b1;
                end else begin
                    s.half = 1'b0;
                    if (h == 16'd0) begin
                        s.done = 1'b1;
                    end else begin
                        // non-ack START/DATA/END wants an acknowledgement
                        if (!h[9] && h[13:10] >= ST_START && h[13:10] <= ST_END) begin
                            s.ack_kind    = h[13:10];
                            s.ack_seq     = h[8:7];
                            s.ack_phase   = h[6:5];
                            s.ack_pending = 1'b1;
                        end
                        s.skip = h[4:0];
                    end
                end
            end
        end
        return s;
    endfunction

    t_scan         scan_base;
    logic [CW-1:0] child_base;
    logic [CW-1:0] peer_base;
    t_join_sub     jsub;
    logic [23:0]   fhdr;
    logic [7:0]    eb [BUF_BYTES];
    logic [6:0]    jbytes;

    // Slot start points and frame pieces
    always_comb begin
        scan_base = r_scan;
        if (!r_child_open) begin
            scan_base.skip = '0;
            scan_base.done = 1'b0;
            scan_base.half = 1'b0;
            scan_base.low  = '0;
        end
        child_base = r_child_open ? r_child_cnt : '0;
        peer_base  = r_peer_open ? r_peer_cnt : '0;
        jsub       = join_entry(r_join_stage);
        jbytes     = 7'(ACK_FRAME_BYTES) + jsub.size;
    end

    // Echo frame bytes: header, peer row, child row, zero beyond
    always_comb begin
        fhdr = llsf_hdr(ST_ECHO, 1'b0, 2'd0, 2'd0, 7'(TABLE_BYTES));
        for (int i = 0; i < BUF_BYTES; i++) begin
            eb[i] = '0;
        end
        eb[0] = fhdr[7:0];
        eb[1] = fhdr[15:8];
        eb[2] = fhdr[23:16];
        for (int i = 0; i < ROW_BYTES; i++) begin
            if (r_peer_cnt > CW'(i / 4)) begin
                eb[3 + i] = r_peer_words[i / 4][8*(i % 4) +: 8];
            end
            if (r_child_cnt > CW'(i / 4)) begin
                eb[3 + ROW_BYTES + i] = r_child_words[i / 4][8*(i % 4) +: 8];
            end
        end
    end

    // Next state
    always_comb begin
        n_join_stage  = r_join_stage;
        n_null_cnt    = r_null_cnt;
        n_scan        = r_scan;
        n_child_words = r_child_words;
        n_child_cnt   = r_child_cnt;
        n_child_open  = r_child_open;
        n_peer_words  = r_peer_words;
        n_peer_cnt    = r_peer_cnt;
        n_peer_open   = r_peer_open;
        n_buf         = r_buf;
        n_hdr         = r_hdr;
        n_last_idx    = r_last_idx;

        // child slot word: store, scan, count
        if (i_cmd.child_wr) begin
            n_scan      = scan_base;
            n_child_cnt = child_base;
            if (child_base < CW'(SLOT_WORDS)) begin
                if (child_base < CW'(KEPT_WORDS)) begin
                    n_child_words[child_base[1:0]] = i_word;
                end
                n_scan      = scan_word(scan_base, i_word);
                n_child_cnt = child_base + CW'(1);
            end
            n_child_open = !i_last;
        end

        // peer slot word: store, count
        if (i_cmd.peer_wr) begin
            n_peer_cnt = peer_base;
            if (peer_base < CW'(SLOT_WORDS)) begin
                if (peer_base < CW'(KEPT_WORDS)) begin
                    n_peer_words[peer_base[1:0]] = i_word;
                end
                n_peer_cnt = peer_base + CW'(1);
            end
            n_peer_open = !i_last;
        end

        if (i_cmd.restart) begin
            n_join_stage       = '0;
            n_null_cnt         = '0;
            n_scan.ack_pending = 1'b0;
        end

        // pull: build the reply frame
        if (i_cmd.pull_load) begin
            for (int k = 0; k < BUF_WORDS; k++) begin
                n_buf[k] = '0;
            end
            if (r_scan.ack_pending) begin
                n_scan.ack_pending = 1'b0;
                n_buf[0]   = {8'h00, llsf_hdr(r_scan.ack_kind, 1'b1, r_scan.ack_seq,
                                              r_scan.ack_phase, 7'd0)};
                n_hdr      = 7'(ACK_FRAME_BYTES);
                n_last_idx = IDX_W'(1);
            end else if (r_join_stage < JOIN_DONE) begin
                n_buf[0]   = {jsub.pay[7:0], llsf_hdr(jsub.st, 1'b0, jsub.sq, jsub.ph,
                                                     jsub.size)};
                n_buf[1]   = jsub.pay[39:8];
                n_hdr      = jbytes;
                n_last_idx = IDX_W'((jbytes + 7'd3) >> 2);
                if (jsub.st == ST_NULL) begin
                    n_null_cnt = r_null_cnt + 2'd1;
                    if (n_null_cnt >= NULL_REPS) begin
                        n_join_stage = JOIN_DONE;
                    end
                end else if (r_join_stage < JOIN_LAST) begin
                    n_join_stage = r_join_stage + 3'd1;
                end
            end else begin
                for (int k = 0; k < BUF_WORDS; k++) begin
                    n_buf[k] = {eb[4*k + 3], eb[4*k + 2], eb[4*k + 1], eb[4*k]};
                end
                n_hdr      = 7'(ECHO_FRAME_BYTES);
                n_last_idx = IDX_W'(ECHO_LAST_IDX);
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_join_stage <= '0;
            r_null_cnt   <= '0;
            r_scan       <= '0;
            r_child_cnt  <= '0;
            r_child_open <= 1'b0;
            r_peer_cnt   <= '0;
            r_peer_open  <= 1'b0;
        end else begin
            r_join_stage <= n_join_stage;
            r_null_cnt   <= n_null_cnt;
            r_scan       <= n_scan;
            r_child_cnt  <= n_child_cnt;
            r_child_open <= n_child_open;
            r_peer_cnt   <= n_peer_cnt;
            r_peer_open  <= n_peer_open;
        end
    end

    // Slot words and reply buffer
    always_ff @(posedge i_clk) begin
        r_child_words <= n_child_words;
        r_peer_words  <= n_peer_words;
        r_buf         <= n_buf;
        r_hdr         <= n_hdr;
        r_last_idx    <= n_last_idx;
    end

    // Reply word select: byte count first, then frame words
    logic [IDX_W-1:0] body_idx;
    always_comb begin
        body_idx = i_cmd.word_idx - IDX_W'(1);
        if (i_cmd.word_idx == '0) begin
            o_reply_word = {25'd0, r_hdr};
        end else if (body_idx < IDX_W'(BUF_WORDS)) begin
            o_reply_word = r_buf[body_idx[$clog2(BUF_WORDS)-1:0]];
        end else begin
            o_reply_word = '0;
        end
    end

    assign o_sts.last_idx = r_last_idx;

endmodule

// File: hw/rtl/ljafr_ctrl.sv
// ----------------------------------------------------------------------------
// Link join/ack frame responder: controller
// Decodes requests into datapath commands and steps the reply words out.
// ----------------------------------------------------------------------------
module ljafr_ctrl import ljafr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic [1:0] i_req_func,
    output logic       o_req_ready,
    output logic       o_rep_valid,
    input  logic       i_rep_ready,
    output logic       o_rep_last,
    output t_dp_cmd    o_cmd,
    input  t_dp_sts    i_sts
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SEND = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             req_take;

    assign req_take    = (r_state == ST_IDLE) && i_req_valid;
    assign o_req_ready = (r_state == ST_IDLE);
    assign o_rep_valid = (r_state == ST_SEND);
    assign o_rep_last  = (r_idx == i_sts.last_idx);

    // Request decode
    always_comb begin
        o_cmd          = '0;
        o_cmd.word_idx = r_idx;
        if (req_take) begin
            unique case (t_func'(i_req_func))
                FN_CHILD:   o_cmd.child_wr  = 1'b1;
                FN_PEER:    o_cmd.peer_wr   = 1'b1;
                FN_RESTART: o_cmd.restart   = 1'b1;
                FN_PULL:    o_cmd.pull_load = 1'b1;
            endcase
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.pull_load) begin
                    n_state = ST_SEND;
                    n_idx   = '0;
                end
            end
            ST_SEND: begin
                if (i_rep_ready) begin
                    if (o_rep_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

// File: hw/rtl/link_join_ack_frame_responder.sv
// ----------------------------------------------------------------------------
// Link join/ack frame responder: top level
// Stores and scans slot words and answers pulls with ack, join or echo
// frames.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries requests: child slot word, peer slot word, restart join,
//   or pull. o_rep carries the reply words of a pull: a byte-count word,
//   then the frame bytes packed four to a word, low byte first; reply_last
//   marks the final word.
//   Slot words and restarts are taken one per cycle while i_req.ready is high and give no reply.
//   A pull taken at one clock edge presents its byte-count word from the
//   next cycle; the reply is 2 words (ack), 2 or 3 words (join) or 20 words
//   (echo), one per cycle while o_rep.ready is high. The reply counter in
//   the controller sets that pace.
//   i_req.ready is low from the pull until its last reply word is taken.
//   When the receiver stalls, the current reply word holds and no request
//   is taken.
//   Reset (i_rst_n low at a clock edge) restarts the join sequence, drops
//   any pending acknowledgement, empties both slots and abandons a reply.
// ----------------------------------------------------------------------------
module link_join_ack_frame_responder import ljafr_pkg::*; #(
    parameter int SLOT_WORDS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ljafr_req_if.sink    i_req,
    ljafr_rep_if.source  o_rep
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Controller
    ljafr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_func  (i_req.func),
        .o_req_ready (i_req.ready),
        .o_rep_valid (o_rep.valid),
        .i_rep_ready (o_rep.ready),
        .o_rep_last  (o_rep.reply_last),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // Datapath
    ljafr_datapath #(
        .SLOT_WORDS (SLOT_WORDS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_word       (i_req.word),
        .i_last       (i_req.last),
        .o_sts        (sts),
        .o_reply_word (o_rep.reply_word)
    );

endmodule

// File: hw/rtl/ljafr_chk.sv
// ----------------------------------------------------------------------------
// Link join/ack frame responder: port checker
// Watches the request and reply channels and checks the reply sequencing.
// ----------------------------------------------------------------------------
`include "link_join_ack_frame_responder_defines.svh"

module ljafr_chk import ljafr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ljafr_req_if.sink   i_req,
    ljafr_rep_if.source o_rep
);

    logic pull_take;
    logic rep_take;
    logic hdr_legal;

    assign pull_take = i_req.valid && i_req.ready && (i_req.func == FN_PULL);
    assign rep_take  = o_rep.valid && o_rep.ready;

    // byte counts a reply can carry: ack, join subframes, echo
    assign hdr_legal = (o_rep.reply_word == 32'd3) || (o_rep.reply_word == 32'd4)
                    || (o_rep.reply_word == 32'd5) || (o_rep.reply_word == 32'd8)
                    || (o_rep.reply_word == 32'(ECHO_FRAME_BYTES));

    // no request is taken while a reply is in flight
    `LJAFR_ASSERT_IMP(a_no_req_in_reply, i_clk, i_rst_n, o_rep.valid, !i_req.ready,
                      "request ready during reply")

    // a pull starts its reply at once, with a legal byte count and not final
    `LJAFR_ASSERT_NXT(a_pull_header, i_clk, i_rst_n, pull_take,
                      o_rep.valid && !o_rep.reply_last && hdr_legal, "bad reply header")

    // the reply ends after its last word is taken
    `LJAFR_ASSERT_NXT(a_reply_ends, i_clk, i_rst_n, rep_take && o_rep.reply_last,
                      !o_rep.valid && i_req.ready, "reply continues past last word")

    // a stalled reply word holds
    `LJAFR_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, o_rep.valid && !o_rep.ready,
                      o_rep.valid && $stable(o_rep.reply_word) && $stable(o_rep.reply_last),
                      "stalled reply changed")

endmodule

bind link_join_ack_frame_responder ljafr_chk u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_req   (i_req),
    .o_rep   (o_rep)
);
